[design/uuencode_line_encoder_assert.svh]
// assertion macros for the uuencode line encoder
`ifndef UUENCODE_LINE_ENCODER_ASSERT_SVH
`define UUENCODE_LINE_ENCODER_ASSERT_SVH
`ifndef SYNTHESIS
`define UULE_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("uule assertion failed");
`define UULE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("uule assertion failed");
`else
`define UULE_ASSERT_SAME(label, ante, cons)
`define UULE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[design/uule_pkg.sv]
// package: constants, types and character mapping for the uuencode line encoder
`default_nettype none
package uule_pkg;
   localparam int LINE_BYTES_DEF = 45;
   localparam int BYTE_W         = 8;
   localparam int CHAR_W         = 7;
   localparam int SIX_W          = 6;
   localparam int GROUP_W        = 3 * BYTE_W;
   localparam logic [CHAR_W-1:0] ZERO_CHAR = 7'd96;
   localparam logic [CHAR_W-1:0] CHAR_BIAS = 7'd32;

   typedef enum logic [1:0] {
      S_GATHER,
      S_LEN,
      S_READ,
      S_EMIT
   } uule_state_type;

   function automatic logic [CHAR_W-1:0] code_of(input logic [SIX_W-1:0] v);
      logic [CHAR_W-1:0] c;
      if (v == '0) begin
         c = ZERO_CHAR;
      end else begin
         c = {1'b0, v} + CHAR_BIAS;
      end
      return c;
   endfunction
endpackage
`default_nettype wire

[design/uuencode_line_encoder.sv]
// top level: uuencode line encoder with line store and shared shift sequencer
// flow: after a flushing request is accepted the encoder enters the length state, and the length
// char is registered once the output slot is free; each group of three bytes is then read into
// the shared 24-bit shifter and emitted as four chars, stalling while the receiver holds off
// throughput: one request per cycle while gathering; ready stays low until the line is flushed
// reset: synchronous, clears state, fill count and output valid; line store not cleared
`default_nettype none
`include "uuencode_line_encoder_assert.svh"
module uuencode_line_encoder
   import uule_pkg::*;
#(
   parameter int LINE_BYTES = LINE_BYTES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [BYTE_W-1:0] req_in_byte,
   input  wire logic              req_end_of_message,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [CHAR_W-1:0]      rsp_out_char,
   output logic                   rsp_end_of_line,
   output logic                   rsp_message_done
);
   localparam int ADDR_W = $clog2(LINE_BYTES);
   localparam int CNT_W  = $clog2(LINE_BYTES + 3);

   uule_state_type state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   base_ff, base_in;
   logic [1:0]         step_ff, step_in;
   logic               last_ff, last_in;
   logic [GROUP_W-1:0] grp_ff, grp_in;
   logic [BYTE_W-1:0]  rd_data_ff;
   logic [BYTE_W-1:0]  line_mem [LINE_BYTES];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               eol_ff, eol_in;
   logic               done_ff, done_in;

   logic               slot_free, req_fire, line_end, group_last;
   logic               load_len, load_emit;
   logic [CNT_W-1:0]   rd_pos, cap_pos;
   logic [ADDR_W-1:0]  rd_addr;
   logic [BYTE_W-1:0]  cap_byte;

   // handshake and sequencer outputs
   always_comb begin
      slot_free  = !rsp_valid_ff || rsp_ready;
      req_ready  = (state_ff == S_GATHER);
      req_fire   = req_valid && req_ready;
      line_end   = req_fire && ((fill_ff + CNT_W'(1) == CNT_W'(LINE_BYTES))
                                || req_end_of_message);
      load_len   = (state_ff == S_LEN) && slot_free;
      load_emit  = (state_ff == S_EMIT) && slot_free;
      group_last = (base_ff + CNT_W'(3)) >= fill_ff;
      rd_pos     = base_ff + CNT_W'(step_ff);
      cap_pos    = rd_pos - CNT_W'(1);
      rd_addr    = (rd_pos < CNT_W'(LINE_BYTES)) ? rd_pos[ADDR_W-1:0] : '0;
      cap_byte   = (cap_pos < fill_ff) ? rd_data_ff : '0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_GATHER: if (line_end) state_in = S_LEN;
         S_LEN:    if (slot_free) state_in = S_READ;
         S_READ:   if (step_ff == 2'd3) state_in = S_EMIT;
         S_EMIT: begin
            if (slot_free && step_ff == 2'd3) begin
               state_in = group_last ? S_GATHER : S_READ;
            end
         end
         default:  state_in = S_GATHER;
      endcase
   end

   // counters, shifter and output register
   always_comb begin
      fill_in      = fill_ff;
      base_in      = base_ff;
      step_in      = step_ff;
      last_in      = last_ff;
      grp_in       = grp_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      eol_in       = eol_ff;
      done_in      = done_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_GATHER: begin
            if (req_fire) begin
               fill_in = fill_ff + CNT_W'(1);
               last_in = req_end_of_message;
               base_in = '0;
               step_in = '0;
            end
         end
         S_LEN: begin
            if (load_len) begin
               rsp_valid_in = 1'b1;
               char_in      = code_of(SIX_W'(fill_ff));
               eol_in       = 1'b0;
               done_in      = 1'b0;
            end
         end
         S_READ: begin
            step_in = step_ff + 2'd1;
            if (step_ff != 2'd0) grp_in = {grp_ff[GROUP_W-BYTE_W-1:0], cap_byte};
         end
         S_EMIT: begin
            if (load_emit) begin
               rsp_valid_in = 1'b1;
               char_in      = code_of(grp_ff[GROUP_W-1 -: SIX_W]);
               eol_in       = (step_ff == 2'd3) && group_last;
               done_in      = (step_ff == 2'd3) && group_last && last_ff;
               grp_in       = grp_ff << SIX_W;
               step_in      = step_ff + 2'd1;
               if (step_ff == 2'd3) begin
                  base_in = base_ff + CNT_W'(3);
                  if (group_last) fill_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_GATHER;
         fill_ff      <= '0;
         base_ff      <= '0;
         step_ff      <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         base_ff      <= base_in;
         step_ff      <= step_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff  <= grp_in;
      char_ff <= char_in;
      eol_ff  <= eol_in;
      done_ff <= done_in;
   end

   // line store
   always_ff @(posedge clock) begin
      if (req_fire) line_mem[fill_ff[ADDR_W-1:0]] <= req_in_byte;
      rd_data_ff <= line_mem[rd_addr];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_char     = char_ff;
   assign rsp_end_of_line  = eol_ff;
   assign rsp_message_done = done_ff;

   `UULE_ASSERT_SAME(a_fill_room, state_ff == S_GATHER, fill_ff < CNT_W'(LINE_BYTES))
   `UULE_ASSERT_SAME(a_done_on_eol, rsp_valid && rsp_message_done, rsp_end_of_line)
   `UULE_ASSERT_NEXT(a_flush_stalls, req_fire && req_end_of_message, !req_ready)
   `UULE_ASSERT_SAME(a_base_in_line, state_ff == S_EMIT, base_ff < fill_ff)
endmodule
`default_nettype wire
